[hdl/esaf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esaf_pkg;

  // result codes carried in the lowest bits of the result transfer
  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_SHORT  = 2'd1,
    RES_CRC    = 2'd2,
    RES_STATUS = 2'd3
  } result_code_t;

  // frame layout
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] XOR_FMT0     = 8'h55;
  localparam logic [7:0] XOR_FMT1     = 8'hFF;
  localparam logic [2:0] LEN_FMT0     = 3'd4;
  localparam logic [2:0] LEN_FMT1     = 3'd5;
  localparam logic [2:0] POS_MAX      = 3'd7;

  // 2*pi in Q3.32 (0x6487ED511), split for two narrow constant products
  localparam logic [18:0] TWO_PI_HI   = 19'h6487E;
  localparam logic [15:0] TWO_PI_LO   = 16'hD511;

  // widths of the result fields
  localparam int RAW_W   = 24;
  localparam int ANGLE_W = 27;
  localparam int TOT_W   = 32;
  localparam int PL_W    = RAW_W + 16;
  localparam int PH_W    = RAW_W + 19;
  localparam int SUM_W   = PH_W + 16;

  // one byte through the msb-first crc-8 register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/encoder_spi_angle_frame_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] spi_byte, tlast frame_end
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata[95:0] result fields
// cfg       in   cfg_wen                       cfg_wdata sensor_format
//
// one byte transfer per cycle; bytes that do not end a frame cost no further work
// a frame end yields one result: frame decode into stage a at its transfer edge,
// two constant partial products into stage b, then their sum into the output
// each stage moves when the stage after it is empty or moving, so m_axis_tready low
// stalls the pipe and drops s_axis_tready only once every stage is full
// rst clears frame state, counters, format and all valid flags

module encoder_spi_angle_frame_checker
  import esaf_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] spi_byte
  input  wire logic        s_axis_tlast,   // frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] result_code, [28:2] angle_q3_24, [30:29] sensor_status,
  // [62:31] crc_fault_total, [94:63] warning_total, [95] zero
  output logic [95:0]      m_axis_tdata,
  input  wire logic        cfg_wen,
  input  wire logic [0:0]  cfg_wdata       // [0] sensor_format
);

  // configuration and frame state
  logic                  sensor_format;
  logic [2:0]            byte_position;
  logic [7:0]            crc_accumulator;
  logic [31:0]           payload_shift;
  logic [7:0]            received_check;
  logic [COUNT_BITS-1:0] crc_fault_counter;
  logic [COUNT_BITS-1:0] warning_counter;

  // stage a: decoded frame
  logic                  a_valid;
  result_code_t          a_code;
  logic [RAW_W-1:0]      a_raw;
  logic [1:0]            a_status;
  logic [TOT_W-1:0]      a_crc_tot;
  logic [TOT_W-1:0]      a_warn_tot;

  // stage b: partial products
  logic                  b_valid;
  result_code_t          b_code;
  logic [PL_W-1:0]       b_pl;
  logic [PH_W-1:0]       b_ph;
  logic [1:0]            b_status;
  logic [TOT_W-1:0]      b_crc_tot;
  logic [TOT_W-1:0]      b_warn_tot;

  // output register
  result_code_t          o_code;
  logic [ANGLE_W-1:0]    o_angle;
  logic [1:0]            o_status;
  logic [TOT_W-1:0]      o_crc_tot;
  logic [TOT_W-1:0]      o_warn_tot;

  logic out_free, b_free, a_free, in_xfer;

  // flow control through the stages
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign b_free        = !b_valid || out_free;
  assign a_free        = !a_valid || b_free;
  assign s_axis_tready = a_free;
  assign in_xfer       = s_axis_tvalid && a_free;

  // per-byte decode
  logic                  covered, is_check, crc_ok, len_ok;
  logic [2:0]            pos_next;
  logic [7:0]            crc_next, check_next;
  logic [31:0]           payload_next;
  logic [1:0]            status_now;
  result_code_t          code_now;
  logic [RAW_W-1:0]      raw_now;
  logic [COUNT_BITS-1:0] crc_cnt_next, warn_cnt_next;

  always_comb begin
    if (sensor_format) begin
      covered  = (byte_position < 3'd4);
      is_check = (byte_position == 3'd4);
    end else begin
      covered  = (byte_position == 3'd1) || (byte_position == 3'd2);
      is_check = (byte_position == 3'd3);
    end
    crc_next     = covered ? crc8_byte(crc_accumulator, s_axis_tdata) : crc_accumulator;
    payload_next = covered ? {payload_shift[23:0], s_axis_tdata} : payload_shift;
    check_next   = is_check ? s_axis_tdata : received_check;
    pos_next     = (byte_position < POS_MAX) ? byte_position + 3'd1 : byte_position;

    len_ok = sensor_format ? (pos_next >= LEN_FMT1) : (pos_next >= LEN_FMT0);
    crc_ok = ((crc_next ^ (sensor_format ? XOR_FMT1 : XOR_FMT0)) == check_next);

    code_now      = RES_OK;
    raw_now       = '0;
    status_now    = 2'd0;
    crc_cnt_next  = crc_fault_counter;
    warn_cnt_next = warning_counter;
    if (!len_ok) begin
      code_now = RES_SHORT;
    end else if (!crc_ok) begin
      code_now     = RES_CRC;
      crc_cnt_next = crc_fault_counter + COUNT_BITS'(1);
    end else if (sensor_format) begin
      // 24-bit angle, scaled by 2^-32 after the product
      raw_now    = payload_next[25:2];
      status_now = payload_next[1:0];
      if (status_now != 2'd0) begin
        code_now      = RES_STATUS;
        warn_cnt_next = warning_counter + COUNT_BITS'(1);
      end
    end else begin
      // 16-bit angle moved up 8 bits so both formats share the 2^-32 scale
      raw_now = {payload_next[15:0], 8'h00};
    end
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_format     <= 1'b0;
      byte_position     <= '0;
      crc_accumulator   <= '0;
      payload_shift     <= '0;
      received_check    <= '0;
      crc_fault_counter <= '0;
      warning_counter   <= '0;
    end else begin
      if (cfg_wen) begin
        sensor_format <= cfg_wdata[0];
      end
      if (in_xfer) begin
        if (s_axis_tlast) begin
          byte_position     <= '0;
          crc_accumulator   <= '0;
          payload_shift     <= '0;
          received_check    <= '0;
          crc_fault_counter <= crc_cnt_next;
          warning_counter   <= warn_cnt_next;
        end else begin
          byte_position   <= pos_next;
          crc_accumulator <= crc_next;
          payload_shift   <= payload_next;
          received_check  <= check_next;
        end
      end
    end
  end

  // stage a register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_xfer && s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_code     <= code_now;
      a_raw      <= raw_now;
      a_status   <= status_now;
      a_crc_tot  <= TOT_W'(crc_cnt_next);
      a_warn_tot <= TOT_W'(warn_cnt_next);
    end
  end

  // stage b: two constant products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_code     <= a_code;
      b_pl       <= PL_W'(a_raw) * PL_W'(TWO_PI_LO);
      b_ph       <= PH_W'(a_raw) * PH_W'(TWO_PI_HI);
      b_status   <= a_status;
      b_crc_tot  <= a_crc_tot;
      b_warn_tot <= a_warn_tot;
    end
  end

  // output stage: sum of partial products, keep integer and 24 fraction bits
  logic [SUM_W-1:0] prod_sum;
  assign prod_sum = {b_ph, 16'h0000} + SUM_W'(b_pl);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      o_code     <= b_code;
      o_angle    <= prod_sum[SUM_W-1 -: ANGLE_W];
      o_status   <= b_status;
      o_crc_tot  <= b_crc_tot;
      o_warn_tot <= b_warn_tot;
    end
  end

  assign m_axis_tdata = {1'b0, o_warn_tot, o_crc_tot, o_status, o_angle, o_code};

endmodule

`default_nettype wire

[tb/sv/tb_encoder_spi_angle_frame_checker.sv]
`timescale 1ns / 1ps

module tb_encoder_spi_angle_frame_checker;
  import esaf_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_SETTLE = 8;
  localparam int SEGMENT_BYTES = 120;
  // 2*pi in Q3.32, truncated
  localparam logic [63:0] TWO_PI_Q3_32 = 64'h6_487E_D511;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } spi_item_t;

  typedef struct packed {
    result_code_t code;
    logic [26:0]  angle;
    logic [1:0]   status;
    logic [31:0]  crc_total;
    logic [31:0]  warn_total;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] spi_byte
  logic        s_axis_tlast = 1'b0;    // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] result_code, [28:2] angle_q3_24, [30:29] sensor_status,
  // [62:31] crc_fault_total, [94:63] warning_total
  logic [95:0] m_axis_tdata;
  logic        cfg_wen = 1'b0;
  logic [0:0]  cfg_wdata = 1'b0;       // [0] sensor_format

  // stimulus and expectation stores
  spi_item_t     spi_bytes_pending[$];
  frame_result_t frame_results_due[$];
  spi_item_t     drive_item;
  frame_result_t due;

  // decoder state as the block should hold it
  logic        fmt_now = 1'b0;
  logic [2:0]  frame_pos = '0;
  logic [7:0]  crc_acc = '0;
  logic [31:0] payload = '0;
  logic [7:0]  check_byte = '0;
  logic [31:0] crc_faults = '0;
  logic [31:0] warnings = '0;

  int send_idle_pct = 7;
  int recv_idle_pct = 55;
  int mismatches = 0;
  int bytes_accepted = 0;
  int code_seen[4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  encoder_spi_angle_frame_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // msb-first crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // advance the expected decoder by one accepted byte
  task automatic decode_spi_byte(input logic [7:0] b, input logic fin);
    frame_result_t r;
    logic [63:0]   prod;
    logic [2:0]    need;
    if (fmt_now) begin
      if (frame_pos < 3'd4) begin
        crc_acc = crc8_step(crc_acc, b);
        payload = {payload[23:0], b};
      end else if (frame_pos == 3'd4) begin
        check_byte = b;
      end
    end else begin
      if (frame_pos == 3'd1 || frame_pos == 3'd2) begin
        crc_acc = crc8_step(crc_acc, b);
        payload = {payload[23:0], b};
      end else if (frame_pos == 3'd3) begin
        check_byte = b;
      end
    end
    if (frame_pos != POS_MAX) frame_pos = frame_pos + 3'd1;
    if (fin) begin
      r.code = RES_OK;
      r.angle = '0;
      r.status = '0;
      need = fmt_now ? LEN_FMT1 : LEN_FMT0;
      if (frame_pos < need) begin
        r.code = RES_SHORT;
      end else if ((crc_acc ^ (fmt_now ? XOR_FMT1 : XOR_FMT0)) != check_byte) begin
        r.code = RES_CRC;
        crc_faults = crc_faults + 32'd1;
      end else if (fmt_now) begin
        r.status = payload[1:0];
        if (r.status != 2'd0) begin
          warnings = warnings + 32'd1;
          r.code = RES_STATUS;
        end
        prod = {40'd0, payload[25:2]} * TWO_PI_Q3_32;
        r.angle = prod[58:32];
      end else begin
        prod = {48'd0, payload[15:0]} * TWO_PI_Q3_32;
        r.angle = prod[50:24];
      end
      r.crc_total = crc_faults;
      r.warn_total = warnings;
      frame_results_due.push_back(r);
      frame_pos = '0;
      crc_acc = '0;
      payload = '0;
      check_byte = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_spi_byte(input logic [7:0] b, input logic last);
    spi_bytes_pending.push_back(spi_item_t'{data: b, last: last});
  endtask

  // build a frame of nbytes; bytes past the frame length are random filler
  task automatic queue_frame(input bit f1, input logic [31:0] pay, input bit corrupt,
                             input int nbytes);
    logic [7:0] fr[5];
    logic [7:0] acc;
    int         full;
    full = f1 ? 5 : 4;
    fr[0] = pay[31:24];
    if (f1) begin
      fr[1] = pay[23:16];
      fr[2] = pay[15:8];
      fr[3] = pay[7:0];
      acc = 8'd0;
      for (int i = 0; i < 4; i++) acc = crc8_step(acc, fr[i]);
      fr[4] = acc ^ XOR_FMT1;
    end else begin
      fr[1] = pay[15:8];
      fr[2] = pay[7:0];
      fr[3] = crc8_step(crc8_step(8'd0, fr[1]), fr[2]) ^ XOR_FMT0;
      fr[4] = 8'd0;
    end
    if (corrupt) fr[full - 1] = fr[full - 1] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < nbytes; i++) begin
      push_spi_byte(i < full ? fr[i] : 8'($urandom), i == nbytes - 1);
    end
  endtask

  // wait until every byte is taken and every result is back, then let the pipe settle
  task automatic wait_idle();
    while (spi_bytes_pending.size() != 0 || s_axis_tvalid || frame_results_due.size() != 0)
      @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_format(input logic v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    fmt_now = v;
  endtask

  // byte sender: next transfer once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (spi_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = spi_bytes_pending.pop_front();
        s_axis_tdata <= drive_item.data;
        s_axis_tlast <= drive_item.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver pacing
  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // check result transfers, then fold accepted bytes into the expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        code_seen[m_axis_tdata[1:0]]++;
        if (frame_results_due.size() == 0) begin
          $error("result transfer with no frame pending: %h", m_axis_tdata);
          mismatches++;
        end else begin
          due = frame_results_due.pop_front();
          check_field("result_code", 32'(due.code), 32'(m_axis_tdata[1:0]));
          check_field("angle_q3_24", 32'(due.angle), 32'(m_axis_tdata[28:2]));
          check_field("sensor_status", 32'(due.status), 32'(m_axis_tdata[30:29]));
          check_field("crc_fault_total", due.crc_total, m_axis_tdata[62:31]);
          check_field("warning_total", due.warn_total, m_axis_tdata[94:63]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_accepted++;
        decode_spi_byte(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    int          queued;
    int          sel;
    int          nb;
    bit          f1;
    logic [31:0] pay;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_format(1'b0);

    // short frame format: max angle, crc fault, short frame, long frame past saturation
    queue_frame(1'b0, 32'hFF00_FFFF, 1'b0, 4);
    queue_frame(1'b0, 32'h0000_1234, 1'b1, 4);
    queue_frame(1'b0, 32'h0000_ABCD, 1'b0, 2);
    queue_frame(1'b0, 32'h5A00_0000, 1'b0, 8);
    // format switched mid-frame, short to long
    push_spi_byte(8'h00, 1'b0);
    push_spi_byte(8'hFF, 1'b0);
    wait_idle();
    write_format(1'b1);
    push_spi_byte(8'h81, 1'b0);
    push_spi_byte(8'h7E, 1'b0);
    push_spi_byte(8'hC3, 1'b1);
    // long frame format: max angle, status warning, crc fault, one-byte frame
    queue_frame(1'b1, 32'hFFFF_FFFC, 1'b0, 5);
    queue_frame(1'b1, 32'h0000_0003, 1'b0, 5);
    queue_frame(1'b1, 32'h1234_5679, 1'b1, 5);
    queue_frame(1'b1, 32'hFFFF_FFFF, 1'b0, 1);
    // format switched mid-frame, long to short
    push_spi_byte(8'hA5, 1'b0);
    push_spi_byte(8'h3C, 1'b0);
    wait_idle();
    write_format(1'b0);
    push_spi_byte(8'h96, 1'b0);
    push_spi_byte(8'h69, 1'b1);

    // random frames under three pacing modes, both formats in each
    for (int ph = 0; ph < 3; ph++) begin
      for (int half = 0; half < 2; half++) begin
        wait_idle();
        send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 55 : 0;
        recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 7 : 0;
        f1 = 1'((ph + half) % 2);
        write_format(f1);
        queued = 0;
        while (queued < SEGMENT_BYTES) begin
          sel = $urandom_range(99);
          pay = $urandom;
          if (f1 && $urandom_range(1)) pay[1:0] = 2'd0;
          if (sel < 95) begin
            if (sel < 80) nb = f1 ? 5 : 4;
            else if (sel < 88) nb = $urandom_range(1, f1 ? 4 : 3);
            else nb = $urandom_range(f1 ? 6 : 5, 12);
            queue_frame(f1, pay, (sel >= 70 && sel < 80) || (sel >= 88 && $urandom_range(1)), nb);
          end else begin
            // noise frame of random bytes
            nb = $urandom_range(1, 8);
            for (int i = 0; i < nb; i++) push_spi_byte(8'($urandom), i == nb - 1);
          end
          queued += nb;
        end
      end
    end

    wait_idle();
    $display("accepted %0d spi bytes in both frame formats under three pacing modes",
             bytes_accepted);
    $display("results seen: ok %0d, short %0d, crc fault %0d, status warning %0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
